/* hdl/ttrc_pkg.sv */
// Package for the three-term recurrence checksum.
// Holds the modulus, recurrence constants and the end-around fold function.
// No dependencies.
`default_nettype none

package ttrc_pkg;

  localparam int unsigned TermW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DiffW  = 26;

  localparam logic [TermW-1:0] ModValue    = 16'hFFFF;
  localparam logic [TermW-1:0] TermReset   = 16'd1;
  localparam logic [TermW-1:0] FirstOffset = 16'd7;
  localparam logic [ByteW-1:0] AlphaMul    = 8'd17;
  localparam logic [ByteW-1:0] BetaMul     = 8'd31;
  localparam logic [ByteW-1:0] IdxReset    = 8'd0;
  localparam logic [ByteW-1:0] IdxFirst    = 8'd1;
  // 256 * 65535: lifts any difference of the two products above zero
  localparam logic [DiffW-1:0] DiffBias    = 26'd16776960;

  // reduce a nonnegative value mod 65535 by folding the upper half onto the lower
  function automatic logic [TermW-1:0] mod_fold(input logic [DiffW-1:0] x);
    logic [TermW:0] s1;
    logic [TermW:0] s2;
    begin
      s1 = 17'(x[DiffW-1:TermW]) + 17'(x[TermW-1:0]);
      s2 = 17'(s1[TermW]) + 17'(s1[TermW-1:0]);
      if (s2 >= 17'(ModValue)) begin
        mod_fold = 16'(s2 - 17'(ModValue));
      end else begin
        mod_fold = s2[TermW-1:0];
      end
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/three_term_recurrence_checksum_top.sv */
// Timing: an accepted byte is captured in the input register; when the last
// byte advances out of it, its checksum is written to the output register
// and out_valid_o rises.
// Throughput: one byte per cycle unless stalled; the term update (two products
// of 16-bit terms, a subtract and a mod-65535 fold) is combinational logic.
// Input stalls only while a last word waits on an unread full output register.
// Reset: asynchronous, active low; clears both stages and sets the terms to 1
// and the index to 0.
// Top level of the three-term recurrence checksum; depends on ttrc_pkg.
`default_nettype none

module three_term_recurrence_checksum_top
  import ttrc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [ByteW-1:0]    data_byte_i,
  input  wire logic                first_byte_i,
  input  wire logic                last_byte_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [TermW-1:0]         checksum_o
);

  logic               s1_valid_q;
  logic [ByteW-1:0]   s1_byte_q;
  logic               s1_first_q;
  logic               s1_last_q;
  logic               s1_adv;

  logic [TermW-1:0]   older_q, older_d;
  logic [TermW-1:0]   newer_q, newer_d;
  logic [ByteW-1:0]   idx_q, idx_d;

  logic               out_valid_q;
  logic [TermW-1:0]   out_sum_q;

  logic [ByteW-1:0]   alpha;
  logic [ByteW-1:0]   beta;
  logic [ByteW:0]     coef_a;
  logic [24:0]        prod_a;
  logic [23:0]        prod_b;
  logic               neg;
  logic [DiffW-1:0]   diff;
  logic [TermW-1:0]   next_term;

  // advance a valid input register unless its last-byte result is blocked by a full output
  assign s1_adv     = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    alpha     = 8'(idx_q * AlphaMul);
    beta      = 8'(idx_q * BetaMul);
    coef_a    = 9'(s1_byte_q) + 9'(alpha);
    prod_a    = 25'(coef_a) * 25'(newer_q);
    prod_b    = 24'(beta) * 24'(older_q);
    neg       = 25'(prod_b) > prod_a;
    diff      = 26'(prod_a) + DiffBias + 26'(neg) - 26'(prod_b);
    next_term = mod_fold(diff);

    if (s1_first_q) begin
      older_d = TermReset;
      newer_d = 16'(s1_byte_q) + FirstOffset;
      idx_d   = IdxFirst;
    end else begin
      older_d = newer_q;
      newer_d = next_term;
      idx_d   = 8'(idx_q + 8'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_first_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      older_q     <= TermReset;
      newer_q     <= TermReset;
      idx_q       <= IdxReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
        s1_first_q <= first_byte_i;
        s1_last_q  <= last_byte_i;
      end
      if (s1_adv) begin
        older_q <= older_d;
        newer_q <= newer_d;
        idx_q   <= idx_d;
      end
      if (s1_adv && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      s1_byte_q <= data_byte_i;
    end
    if (s1_adv && s1_last_q) begin
      out_sum_q <= newer_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign checksum_o  = out_sum_q;

  a_newer_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    newer_q != ModValue)
    else $error("newer term reached the modulus");

  a_older_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    older_q != ModValue)
    else $error("older term reached the modulus");

  a_first_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_first_q |=> idx_q == IdxFirst && older_q == TermReset)
    else $error("first byte did not restart the recurrence");

  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv && s1_last_q))
    else $error("result appeared without a last byte");

endmodule

`default_nettype wire
